[src/fh64_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fh64_pkg;

   // Hash constants
   localparam logic [63:0] FH_MULT = 64'h880355f21e6d1965;
   localparam logic [63:0] FH_MIXK = 64'h2127599bf4325c37;
   localparam int unsigned FH_SHIFT_HEAD = 23;
   localparam int unsigned FH_SHIFT_TAIL = 47;

   // Bytes in one data word
   localparam logic [3:0] FH_FULL_BYTES = 4'd8;

   // Iterative multiplier: three 32x32 partial products
   localparam logic [1:0] FH_MUL_LAST_STEP = 2'd2;

   // Default depth of the command queue between front and back
   localparam int FH_QUEUE_DEPTH = 2;

   // One classified word as handed from the front to the back
   typedef struct packed {
      logic [63:0] word;      // masked data word
      logic        has_data;  // at least one valid byte
      logic        first;
      logic        last;
      logic [63:0] seed;
      logic [31:0] len;
   } fh_cmd_type;

   // First half of the word mix
   function automatic logic [63:0] fh_mix_head(input logic [63:0] x);
      fh_mix_head = x ^ (x >> FH_SHIFT_HEAD);
   endfunction

   // Second half of the word mix
   function automatic logic [63:0] fh_mix_tail(input logic [63:0] x);
      fh_mix_tail = x ^ (x >> FH_SHIFT_TAIL);
   endfunction

   // Clear the bytes at and above the valid byte count
   function automatic logic [63:0] fh_mask_word(input logic [63:0] word,
                                                input logic [3:0]  cnt);
      logic [63:0] res;
      res = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < cnt) begin
            res[i*8 +: 8] = word[i*8 +: 8];
         end
      end
      fh_mask_word = res;
   endfunction

endpackage

`default_nettype wire

[src/fh64_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one message word per handshake
interface fh64_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  byte_count;
   logic        first_item;
   logic        last_item;
   logic [63:0] seed_value;
   logic [31:0] total_length;

   modport source (
      output valid, data_word, byte_count, first_item, last_item,
             seed_value, total_length,
      input  ready
   );
   modport sink (
      input  valid, data_word, byte_count, first_item, last_item,
             seed_value, total_length,
      output ready
   );
endinterface

// Response channel: one final hash per handshake
interface fh64_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;

   modport source (
      output valid, hash_value,
      input  ready
   );
   modport sink (
      input  valid, hash_value,
      output ready
   );
endinterface

`default_nettype wire

[src/fh64_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module fh64_front
   import fh64_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   fh64_req_if.sink        req_chan,
   input  wire logic       q_full,
   output fh_cmd_type      q_push_data,
   output logic            q_push
);

   logic       in_msg_ff;
   logic       in_msg_in;
   logic       accept;
   logic [3:0] cnt_sat;

   // Take a word whenever the queue has room
   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Drop words that arrive outside a message
   assign q_push = accept && (req_chan.first_item || in_msg_ff);

   // Saturate the byte count and clear unused bytes
   assign cnt_sat = (req_chan.byte_count > FH_FULL_BYTES) ? FH_FULL_BYTES
                                                          : req_chan.byte_count;

   always_comb begin
      q_push_data.word     = fh_mask_word(req_chan.data_word, cnt_sat);
      q_push_data.has_data = (cnt_sat != 4'd0);
      q_push_data.first    = req_chan.first_item;
      q_push_data.last     = req_chan.last_item;
      q_push_data.seed     = req_chan.seed_value;
      q_push_data.len      = req_chan.total_length;
   end

   // Track whether a message is open
   always_comb begin
      in_msg_in = in_msg_ff;
      if (q_push) begin
         in_msg_in = !req_chan.last_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
      end
   end

endmodule

`default_nettype wire

[src/fh64_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module fh64_queue
   import fh64_pkg::*;
#(
   parameter int DEPTH = FH_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire fh_cmd_type  push_data,
   output logic             full,
   output logic             head_valid,
   output fh_cmd_type       head_data,
   input  wire logic        pop
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   fh_cmd_type            mem_ff [DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff,  count_in;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and keep the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/fh64_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Low 64 bits of a 64x64 product from three 32x32 partial products,
// one per cycle; done pulses the cycle after the last step and the
// product holds until the next start.
module fh64_mul
   import fh64_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] op_a,
   input  wire logic [63:0] op_b,
   output logic             done,
   output logic [63:0]      product
);

   logic [63:0] a_ff, b_ff;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] fac_a, fac_b;
   logic [63:0] part;

   // Pick the halves for this step
   always_comb begin
      case (step_ff)
         2'd0: begin
            fac_a = a_ff[31:0];
            fac_b = b_ff[31:0];
         end
         2'd1: begin
            fac_a = a_ff[31:0];
            fac_b = b_ff[63:32];
         end
         default: begin
            fac_a = a_ff[63:32];
            fac_b = b_ff[31:0];
         end
      endcase
   end

   assign part = 64'(fac_a) * 64'(fac_b);

   // Accumulate: low product whole, cross products into the upper half
   always_comb begin
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (step_ff == 2'd0) begin
            acc_in = part;
         end else begin
            acc_in = {acc_ff[63:32] + part[31:0], acc_ff[31:0]};
         end
         if (step_ff == FH_MUL_LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Hold operands and the running sum
   always_ff @(posedge clock) begin
      if (!busy_ff && start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

[src/fh64_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module fh64_back
   import fh64_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   input  wire fh_cmd_type q_head,
   output logic            q_pop,
   fh64_rsp_if.source      rsp_chan
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SEED = 6'b000010,
      ST_MIX  = 6'b000100,
      ST_FOLD = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_EMIT = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [63:0]    hash_ff, hash_in;
   logic           out_valid_ff, out_valid_in;
   logic [63:0]    out_hash_ff;
   logic           out_load;
   logic           mul_start;
   logic [63:0]    mul_a, mul_b;
   logic           mul_done;
   logic [63:0]    mul_p;
   logic [63:0]    hash_seed;
   logic [63:0]    hash_sel;
   logic           dispatch;

   fh64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   assign hash_seed = q_head.seed ^ mul_p;
   assign hash_sel  = (state_ff == ST_SEED) ? hash_seed : hash_ff;

   // Sequence one word: seed, mix, fold, final mix, emit
   always_comb begin
      state_in  = state_ff;
      hash_in   = hash_ff;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      q_pop     = 1'b0;
      out_load  = 1'b0;
      dispatch  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_head.first) begin
                  mul_start = 1'b1;
                  mul_a     = {32'd0, q_head.len};
                  mul_b     = FH_MULT;
                  state_in  = ST_SEED;
               end else begin
                  dispatch = 1'b1;
               end
            end
         end
         ST_SEED: begin
            if (mul_done) begin
               hash_in  = hash_seed;
               dispatch = 1'b1;
            end
         end
         ST_MIX: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = hash_ff ^ fh_mix_tail(mul_p);
               mul_b     = FH_MULT;
               state_in  = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (mul_done) begin
               hash_in = mul_p;
               if (q_head.last) begin
                  mul_start = 1'b1;
                  mul_a     = fh_mix_head(mul_p);
                  mul_b     = FH_MIXK;
                  state_in  = ST_FIN;
               end else begin
                  q_pop    = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIN: begin
            if (mul_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               hash_in  = '0;
               q_pop    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Once the hash is known: mix the word, finish, or retire
      if (dispatch) begin
         if (q_head.has_data) begin
            mul_start = 1'b1;
            mul_a     = fh_mix_head(q_head.word);
            mul_b     = FH_MIXK;
            state_in  = ST_MIX;
         end else if (q_head.last) begin
            mul_start = 1'b1;
            mul_a     = fh_mix_head(hash_sel);
            mul_b     = FH_MIXK;
            state_in  = ST_FIN;
         end else begin
            q_pop    = 1'b1;
            state_in = ST_IDLE;
         end
      end
   end

   // Output register: load a result, drop it when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_hash_ff <= fh_mix_tail(mul_p);
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.hash_value = out_hash_ff;

endmodule

`default_nettype wire

[src/fasthash64_stream.sv]
// A middle word with data takes two passes (word mix and hash fold) through
// the shared 32x32 multiplier; the first word adds one for the seed product,
// the last adds one for the final mix, then the output register. The single
// iterative multiplier takes one word at a time; the queue holds later words.
// Middle words without data bytes retire with no pass. Synchronous active-high
// reset clears the open-message flag, queue, running hash and output valid.
`timescale 1ns / 1ps
`default_nettype none

module fasthash64_stream
   import fh64_pkg::*;
#(
   parameter int QUEUE_DEPTH = FH_QUEUE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fh64_req_if.sink   req_chan,
   fh64_rsp_if.source rsp_chan
);

   fh_cmd_type push_data;
   fh_cmd_type head_data;
   logic       push;
   logic       full;
   logic       head_valid;
   logic       pop;

   fh64_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .q_full      (full),
      .q_push_data (push_data),
      .q_push      (push)
   );

   fh64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   fh64_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (head_valid),
      .q_head   (head_data),
      .q_pop    (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[src/fh64_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module fh64_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_hash
);

   // Reset leaves no result pending
   a_reset_no_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending right after reset");

   // Reset leaves the queue empty, so words are taken at once
   a_reset_ready: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("request side not ready after reset");

   // A stalled result holds its hash
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash))
      else $error("stalled result changed or dropped");

endmodule

bind fasthash64_stream fh64_checker u_fh64_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hash  (rsp_chan.hash_value)
);

`default_nettype wire

[tb/sv/tb_fasthash64_stream.sv]
`timescale 1ns / 1ps

module tb_fasthash64_stream;
   import fh64_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;

   // Track the running hash of the open message and queue the finished hashes
   class fasthash_predictor;
      logic [63:0] hash_acc;
      bit          msg_open;
      logic [63:0] hashes_due[$];
      int          errors;

      function new();
         hash_acc = '0;
         msg_open = 1'b0;
         errors = 0;
      endfunction

      function logic [63:0] mix_word(logic [63:0] x);
         x = x ^ (x >> FH_SHIFT_HEAD);
         x = x * FH_MIXK;
         x = x ^ (x >> FH_SHIFT_TAIL);
         return x;
      endfunction

      // Fold one accepted word into the hash; queue the hash on the last word
      function void absorb_word(logic [63:0] data, logic [3:0] cnt, bit first, bit last,
                                logic [63:0] seed, logic [31:0] len);
         logic [63:0] acc;
         logic [63:0] masked;
         int unsigned nbytes;
         if (first) begin
            acc = seed ^ (64'(len) * FH_MULT);
         end else if (msg_open) begin
            acc = hash_acc;
         end else begin
            return;
         end
         nbytes = (cnt > 8) ? 8 : cnt;
         if (nbytes != 0) begin
            masked = data & (~64'd0 >> (64 - 8 * nbytes));
            acc = (acc ^ mix_word(masked)) * FH_MULT;
         end
         if (last) begin
            hashes_due.push_back(mix_word(acc));
            hash_acc = '0;
            msg_open = 1'b0;
         end else begin
            hash_acc = acc;
            msg_open = 1'b1;
         end
      endfunction

      function void check_hash(logic [63:0] got);
         logic [63:0] want;
         if (hashes_due.size() == 0) begin
            $display("%0t: unexpected hash: expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = hashes_due.pop_front();
         if (got !== want) begin
            $display("%0t: hash_value mismatch: expected %h, actual %h", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   fh64_req_if req_chan();
   fh64_rsp_if rsp_chan();

   fasthash_predictor hasher = new();

   int send_idle_pct = 15;
   int recv_idle_pct = 71;
   bit hold_rsp_request = 1'b0;
   int words_fed = 0;
   bit sent_open = 1'b0;

   fasthash64_stream dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Check results before noting the word taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            hasher.check_hash(rsp_chan.hash_value);
         end
         if (req_chan.valid && req_chan.ready) begin
            hasher.absorb_word(req_chan.data_word, req_chan.byte_count, req_chan.first_item,
                               req_chan.last_item, req_chan.seed_value,
                               req_chan.total_length);
         end
      end
   end

   // Drive rsp ready: random stalls, plus one long hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // End the run when nothing moves on either channel for too long
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("fasthash64_stream regression: fail");
      $finish;
   end

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Offer one word after random idle cycles and hold it until accepted
   task automatic send_word(input logic [63:0] data, input logic [3:0] cnt, input bit first,
                            input bit last, input logic [63:0] seed, input logic [31:0] len);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.data_word = data;
      req_chan.byte_count = cnt;
      req_chan.first_item = first;
      req_chan.last_item = last;
      req_chan.seed_value = seed;
      req_chan.total_length = len;
      do @(posedge clock); while (!req_chan.ready);
      // count only words the block does not drop
      if (first || sent_open) begin
         words_fed++;
      end
      sent_open = first ? !last : (sent_open && !last);
   endtask

   // Mostly well-formed messages, some noise words and abandoned messages
   task automatic send_message();
      int unsigned kind;
      int unsigned n_full;
      int unsigned tail;
      int unsigned n_mid;
      logic [63:0] seed;
      logic [31:0] len;
      bit          closing_empty;
      kind = $urandom_range(0, 99);
      seed = rand_word();
      if ($urandom_range(0, 19) == 0) begin
         seed = $urandom_range(0, 1) ? '1 : '0;
      end
      if (kind < 80) begin
         n_full = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 20);
         tail = $urandom_range(0, 7);
         len = ($urandom_range(0, 9) == 0) ? 32'($urandom()) : 32'(n_full * 8 + tail);
         closing_empty = (tail == 0) && ((n_full == 0) || ($urandom_range(0, 3) == 0));
         for (int i = 0; i < n_full; i++) begin
            send_word(rand_word(), FH_FULL_BYTES, i == 0,
                      (i == n_full - 1) && (tail == 0) && !closing_empty, seed, len);
         end
         if ((tail != 0) || closing_empty) begin
            send_word(rand_word(), 4'(tail), n_full == 0, 1'b1, seed, len);
         end
      end else if (kind < 90) begin
         send_word(rand_word(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), seed, 32'($urandom()));
      end else begin
         // start a message and leave it open for the next first word
         send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b1, 1'b0, seed, 32'($urandom()));
         n_mid = $urandom_range(0, 2);
         repeat (n_mid) begin
            send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, rand_word(),
                      32'($urandom()));
         end
      end
   endtask

   initial begin : stimulus
      req_chan.valid = 1'b0;
      req_chan.data_word = '0;
      req_chan.byte_count = '0;
      req_chan.first_item = 1'b0;
      req_chan.last_item = 1'b0;
      req_chan.seed_value = '0;
      req_chan.total_length = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty messages at both seed and length extremes
      send_word('0, 4'd0, 1'b1, 1'b1, '0, '0);
      send_word('1, 4'd0, 1'b1, 1'b1, '1, '1);
      // words with no open message are dropped
      send_word('1, FH_FULL_BYTES, 1'b0, 1'b1, '1, '1);
      send_word('1, FH_FULL_BYTES, 1'b0, 1'b0, '0, '0);
      // last word with no valid bytes
      send_word('1, FH_FULL_BYTES, 1'b1, 1'b0, '0, 32'd16);
      send_word('0, FH_FULL_BYTES, 1'b0, 1'b0, '0, '0);
      send_word('1, 4'd0, 1'b0, 1'b1, '0, '0);
      // partial words ahead of the end
      send_word('1, 4'd3, 1'b1, 1'b0, 64'h0123456789abcdef, 32'd15);
      send_word('1, 4'd5, 1'b0, 1'b0, '0, '0);
      send_word('1, 4'd7, 1'b0, 1'b1, '0, '0);
      // oversize byte counts saturate
      send_word(rand_word(), 4'd15, 1'b1, 1'b0, rand_word(), 32'd16);
      send_word(rand_word(), 4'd9, 1'b0, 1'b1, rand_word(), '0);
      // new first word abandons the open message
      send_word(rand_word(), FH_FULL_BYTES, 1'b1, 1'b0, rand_word(), 32'd24);
      send_word(rand_word(), FH_FULL_BYTES, 1'b1, 1'b0, rand_word(), 32'd12);
      send_word(rand_word(), 4'd4, 1'b0, 1'b1, '0, '0);
      // single-word messages of a full word and of one to six bytes
      send_word(rand_word(), FH_FULL_BYTES, 1'b1, 1'b1, rand_word(), 32'd8);
      for (int c = 1; c < 7; c++) begin
         send_word('1, 4'(c), 1'b1, 1'b1, rand_word(), 32'(c));
      end
      // empty word in the middle of a message
      send_word(rand_word(), FH_FULL_BYTES, 1'b1, 1'b0, '0, '1);
      send_word(rand_word(), 4'd0, 1'b0, 1'b0, '0, '0);
      send_word(rand_word(), FH_FULL_BYTES, 1'b0, 1'b1, '0, '0);

      while (words_fed < 270) send_message();
      send_idle_pct = 71;
      recv_idle_pct = 15;
      while (words_fed < 520) send_message();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_rsp_request = 1'b1;
      while (words_fed < 775) send_message();

      // drain
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (hasher.hashes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (hasher.errors == 0) begin
         $display("fasthash64_stream regression: pass");
      end else begin
         $display("fasthash64_stream regression: fail");
      end
      $finish;
   end

endmodule
